/* design/xss_pkg.sv */
// Shared types, constants and reset values for the xoshiro256** generator.
`timescale 1ns / 1ps

package xss_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned HALF_W = WORD_W / 2;
	localparam int unsigned NUM_WORDS = 4;
	localparam int unsigned FRAC_W = 53;
	localparam int unsigned FRAC_LSB = WORD_W - FRAC_W;

	localparam logic [WORD_W-1:0] SM_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [WORD_W-1:0] SM_MUL1 = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [WORD_W-1:0] SM_MUL2 = 64'h94D0_49BB_1331_11EB;

	typedef logic [NUM_WORDS-1:0][WORD_W-1:0] xss_words_t;

	// One queued request: whether the state is reloaded from the seed first.
	typedef struct packed {
		logic restart;
	} xss_req_t;

	// Handshake between the back end and the seeding unit.
	typedef struct packed {
		logic start;
	} xss_seed_cmd_t;

	typedef struct packed {
		logic done;
	} xss_seed_sts_t;

	typedef enum logic [1:0] {
		BK_RUN,
		BK_SEED,
		BK_FRESH
	} xss_back_state_t;

	typedef enum logic [1:0] {
		SM_IDLE,
		SM_ADD,
		SM_MUL,
		SM_DONE
	} xss_seed_state_t;

	// Elaboration-time splitmix64 output k (from 0) of a zero seed.
	function automatic logic [WORD_W-1:0] reset_word(input int k);
		logic [WORD_W-1:0] acc;
		logic [WORD_W-1:0] z;
		acc = '0;
		for (int i = 0; i <= k; i++) begin
			acc = acc + SM_GOLDEN;
		end
		z = acc ^ (acc >> 30);
		z = z * SM_MUL1;
		z = z ^ (z >> 27);
		z = z * SM_MUL2;
		return z ^ (z >> 31);
	endfunction

	localparam xss_words_t RESET_WORDS = {reset_word(3), reset_word(2), reset_word(1),
		reset_word(0)};

endpackage

/* design/xss_front.sv */
// Request intake: accepts requests into a two-entry queue for the back end.
`timescale 1ns / 1ps

module xss_front import xss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  logic     restart,
	output logic     head_valid,
	output xss_req_t head,
	input  logic     pop
);

	xss_req_t   entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign req_ready = (count_q != 2'd2);
	assign push = req_valid && req_ready;
	assign head_valid = (count_q != 2'd0);
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q].restart <= restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* design/xss_splitmix.sv */
// Iterative splitmix64 unit that expands the seed into four state words.
`timescale 1ns / 1ps

module xss_splitmix import xss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  xss_seed_cmd_t     cmd,
	input  logic [WORD_W-1:0] seed,
	output xss_seed_sts_t     sts,
	output xss_words_t        words
);

	xss_seed_state_t   state_q;
	xss_seed_state_t   state_d;
	logic [1:0]        word_idx_q;
	logic              round_q;
	logic [1:0]        phase_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] z_q;
	logic [WORD_W-1:0] mp_q;
	logic [WORD_W-1:0] prod_q;
	xss_words_t        words_q;
	logic [WORD_W-1:0] acc_next;
	logic [WORD_W-1:0] mul_const;
	logic [HALF_W-1:0] mul_a;
	logic [HALF_W-1:0] mul_b;
	logic [WORD_W-1:0] mul_p;
	logic [WORD_W-1:0] prod_sum;
	logic              last_phase;

	assign acc_next = acc_q + SM_GOLDEN;
	assign mul_const = round_q ? SM_MUL2 : SM_MUL1;
	assign mul_p = mul_a * mul_b;
	assign prod_sum = prod_q + {mp_q[HALF_W-1:0], {HALF_W{1'b0}}};
	assign last_phase = (phase_q == 2'd3);
	assign words = words_q;

	// The low 64 bits of a 64x64 product take three 32x32 partial products.
	always_comb begin
		case (phase_q)
			2'd0: begin
				mul_a = z_q[HALF_W-1:0];
				mul_b = mul_const[HALF_W-1:0];
			end
			2'd1: begin
				mul_a = z_q[HALF_W-1:0];
				mul_b = mul_const[WORD_W-1:HALF_W];
			end
			default: begin
				mul_a = z_q[WORD_W-1:HALF_W];
				mul_b = mul_const[HALF_W-1:0];
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			SM_IDLE: begin
				if (cmd.start) begin
					state_d = SM_ADD;
				end
			end
			SM_ADD: begin
				state_d = SM_MUL;
			end
			SM_MUL: begin
				if (last_phase && round_q) begin
					state_d = (word_idx_q == 2'd3) ? SM_DONE : SM_ADD;
				end
			end
			SM_DONE: begin
				state_d = SM_IDLE;
			end
			default: begin
				state_d = SM_IDLE;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			SM_DONE: sts.done = 1'b1;
			default: sts.done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SM_IDLE;
			word_idx_q <= 2'd0;
			round_q <= 1'b0;
			phase_q <= 2'd0;
		end else begin
			state_q <= state_d;
			case (state_q)
				SM_IDLE: begin
					word_idx_q <= 2'd0;
				end
				SM_ADD: begin
					round_q <= 1'b0;
					phase_q <= 2'd0;
				end
				SM_MUL: begin
					phase_q <= phase_q + 2'd1;
					if (last_phase) begin
						round_q <= ~round_q;
						if (round_q) begin
							word_idx_q <= word_idx_q + 2'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SM_IDLE: begin
				if (cmd.start) begin
					acc_q <= seed;
				end
			end
			SM_ADD: begin
				acc_q <= acc_next;
				z_q <= acc_next ^ (acc_next >> 30);
			end
			SM_MUL: begin
				mp_q <= mul_p;
				if (phase_q == 2'd1) begin
					prod_q <= mp_q;
				end else if (phase_q == 2'd2) begin
					prod_q <= prod_sum;
				end else if (last_phase) begin
					if (round_q) begin
						words_q[word_idx_q] <= prod_sum ^ (prod_sum >> 31);
					end else begin
						z_q <= prod_sum ^ (prod_sum >> 27);
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* design/xss_back.sv */
// Back end: holds the generator state, runs reseeding and produces draws.
`timescale 1ns / 1ps

module xss_back import xss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WORD_W-1:0] seed,
	input  logic              head_valid,
	input  xss_req_t          head,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [WORD_W-1:0] value,
	output logic [FRAC_W-1:0] unit_fraction
);

	xss_back_state_t   state_q;
	xss_back_state_t   state_d;
	xss_words_t        s_q;
	xss_words_t        s_next;
	xss_words_t        seed_words;
	xss_seed_cmd_t     seed_cmd;
	xss_seed_sts_t     seed_sts;
	logic              res_valid_q;
	logic [WORD_W-1:0] value_q;
	logic              can_out;
	logic              draw;
	logic [WORD_W-1:0] times5;
	logic [WORD_W-1:0] rot7;
	logic [WORD_W-1:0] draw_value;
	logic [WORD_W-1:0] s02;
	logic [WORD_W-1:0] s31;

	xss_splitmix u_splitmix (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (seed_cmd),
		.seed   (seed),
		.sts    (seed_sts),
		.words  (seed_words)
	);

	assign can_out = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign value = value_q;
	assign unit_fraction = value_q[WORD_W-1:FRAC_LSB];

	// Scrambler: multiplications by 5 and 9 reduce to shift-and-add.
	assign times5 = s_q[1] + (s_q[1] << 2);
	assign rot7 = {times5[WORD_W-8:0], times5[WORD_W-1:WORD_W-7]};
	assign draw_value = rot7 + (rot7 << 3);

	assign s02 = s_q[2] ^ s_q[0];
	assign s31 = s_q[3] ^ s_q[1];
	assign s_next[0] = s_q[0] ^ s31;
	assign s_next[1] = s_q[1] ^ s02;
	assign s_next[2] = s02 ^ (s_q[1] << 17);
	assign s_next[3] = {s31[WORD_W-46:0], s31[WORD_W-1:WORD_W-45]};

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_RUN: begin
				if (head_valid && head.restart) begin
					state_d = BK_SEED;
				end
			end
			BK_SEED: begin
				if (seed_sts.done) begin
					state_d = BK_FRESH;
				end
			end
			BK_FRESH: begin
				if (can_out) begin
					state_d = BK_RUN;
				end
			end
			default: begin
				state_d = BK_RUN;
			end
		endcase
	end

	always_comb begin
		seed_cmd.start = 1'b0;
		draw = 1'b0;
		case (state_q)
			BK_RUN: begin
				if (head_valid) begin
					if (head.restart) begin
						seed_cmd.start = 1'b1;
					end else begin
						draw = can_out;
					end
				end
			end
			BK_FRESH: begin
				draw = can_out;
			end
			default: begin
			end
		endcase
	end

	assign pop = draw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_RUN;
			s_q <= RESET_WORDS;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (seed_sts.done) begin
				s_q <= seed_words;
			end else if (draw) begin
				s_q <= s_next;
			end
			if (draw) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (draw) begin
			value_q <= draw_value;
		end
	end

endmodule

/* design/xoshiro256_starstar_generator.sv */
// A request without restart is queued, then drawn once the output can take it, and its
// result is registered. Throughput: one draw per cycle while the output is not stalled;
// the scrambler and the state update are shift/xor/add only. A restart request first
// runs the splitmix64 unit, with its single 32x32 multiplier (three partial products
// per multiply, eight multiplies). Reset clears the queue and output valid, sets the
// seed to zero and loads the state words with their zero-seed splitmix64 expansion at once.
`timescale 1ns / 1ps

module xoshiro256_starstar_generator import xss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              seed_we,
	input  logic [WORD_W-1:0] seed,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              restart,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [WORD_W-1:0] value,
	output logic [FRAC_W-1:0] unit_fraction
);

	logic [WORD_W-1:0] seed_q;
	logic              head_valid;
	xss_req_t          head;
	logic              pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (seed_we) begin
			seed_q <= seed;
		end
	end

	xss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.restart    (restart),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	xss_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.seed          (seed_q),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.value         (value),
		.unit_fraction (unit_fraction)
	);

endmodule

/* tb/sv/xss_draw_checker.sv */
// Checker for the xoshiro256** generator: predicts every draw and compares each result.
`timescale 1ns / 1ps

module xss_draw_checker import xss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              seed_we,
	input  logic [WORD_W-1:0] seed,
	input  logic              req_valid,
	input  logic              req_ready,
	input  logic              restart,
	input  logic              res_valid,
	input  logic              res_ready,
	input  logic [WORD_W-1:0] value,
	input  logic [FRAC_W-1:0] unit_fraction,
	output int                draws_due,
	output int                mismatches
);

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic [FRAC_W-1:0] frac;
	} draw_t;

	logic [WORD_W-1:0] seed_copy;
	logic [WORD_W-1:0] gen_words [NUM_WORDS];
	draw_t expected_draws [$];
	int error_total = 0;

	assign mismatches = error_total;

	function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] z;
		z = (x ^ (x >> 30)) * SM_MUL1;
		z = (z ^ (z >> 27)) * SM_MUL2;
		return z ^ (z >> 31);
	endfunction

	// Each state word is one further splitmix64 output from the running sum.
	function automatic void load_words(input logic [WORD_W-1:0] s);
		logic [WORD_W-1:0] acc;
		int k;
		acc = s;
		for (k = 0; k < NUM_WORDS; k++) begin
			acc = acc + SM_GOLDEN;
			gen_words[k] = mix_word(acc);
		end
	endfunction

	function automatic draw_t next_draw(input logic reload);
		logic [WORD_W-1:0] prod;
		logic [WORD_W-1:0] scrambled;
		logic [WORD_W-1:0] shifted;
		draw_t r;
		if (reload)
			load_words(seed_copy);
		prod = gen_words[1] * 64'd5;
		scrambled = {prod[56:0], prod[63:57]} * 64'd9;
		shifted = gen_words[1] << 17;
		gen_words[2] ^= gen_words[0];
		gen_words[3] ^= gen_words[1];
		gen_words[1] ^= gen_words[2];
		gen_words[0] ^= gen_words[3];
		gen_words[2] ^= shifted;
		gen_words[3] = {gen_words[3][18:0], gen_words[3][63:19]};
		r.value = scrambled;
		r.frac = scrambled[WORD_W-1:FRAC_LSB];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		draw_t want;
		if (!arst_n) begin
			seed_copy = '0;
			load_words('0);
			expected_draws.delete();
			draws_due <= 0;
		end else begin
			if (req_valid && req_ready)
				expected_draws.push_back(next_draw(restart));
			if (seed_we)
				seed_copy = seed;
			if (res_valid && res_ready) begin
				if (expected_draws.size() == 0) begin
					$error("result with no request waiting: value %h", value);
					error_total++;
				end else begin
					want = expected_draws.pop_front();
					if (value !== want.value) begin
						$error("value: expected %h, got %h", want.value, value);
						error_total++;
					end
					if (unit_fraction !== want.frac) begin
						$error("unit_fraction: expected %h, got %h", want.frac,
							unit_fraction);
						error_total++;
					end
				end
			end
			draws_due <= expected_draws.size();
		end
	end

endmodule

/* tb/sv/testbench.sv */
// Top of the xoshiro256** generator testbench: clock, reset, request and seed stimulus.
`timescale 1ns / 1ps

module testbench;
	import xss_pkg::*;

	localparam int NUM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 325;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic seed_we = 1'b0;
	logic [WORD_W-1:0] seed = '0;
	logic req_valid = 1'b0;
	logic restart = 1'b0;
	logic res_ready = 1'b0;
	logic req_ready;
	logic res_valid;
	logic [WORD_W-1:0] value;
	logic [FRAC_W-1:0] unit_fraction;
	int draws_due;
	int mismatches;

	logic steady = 1'b0;
	int send_gap = 0;
	int ready_hold = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	xoshiro256_starstar_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.seed_we(seed_we),
		.seed(seed),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.restart(restart),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.value(value),
		.unit_fraction(unit_fraction)
	);

	xss_draw_checker draw_checker (
		.clk(clk),
		.arst_n(arst_n),
		.seed_we(seed_we),
		.seed(seed),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.restart(restart),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.value(value),
		.unit_fraction(unit_fraction),
		.draws_due(draws_due),
		.mismatches(mismatches)
	);

	// Mostly no gap, sometimes a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
			ready_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Valid is lowered only for a gap before a request or by drain, so back-to-back requests keep it high.
	task automatic send_draw(input logic reload);
		if (send_gap > 0) begin
			req_valid <= 1'b0;
			repeat (send_gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		restart <= reload;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		send_gap = pick_gap();
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (draws_due != 0)
			@(posedge clk);
	endtask

	task automatic write_seed(input logic [WORD_W-1:0] v);
		seed_we <= 1'b1;
		seed <= v;
		@(posedge clk);
		seed_we <= 1'b0;
	endtask

	initial begin
		logic [WORD_W-1:0] phase_seed;
		int p;
		int k;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Draws from the reset state, then a restart from the zero seed.
		repeat (3) send_draw(1'b0);
		send_draw(1'b1);
		send_draw(1'b0);
		send_draw(1'b0);

		// A new seed must not disturb the state until a restart asks for it.
		drain();
		write_seed('1);
		send_draw(1'b0);
		send_draw(1'b0);
		send_draw(1'b1);
		send_draw(1'b0);
		send_draw(1'b1);
		send_draw(1'b1);
		send_draw(1'b0);

		drain();
		write_seed(64'd1);
		send_draw(1'b1);
		send_draw(1'b0);
		drain();
		write_seed(64'h8000_0000_0000_0000);
		send_draw(1'b1);
		send_draw(1'b0);

		for (p = 0; p < NUM_PHASES; p++) begin
			drain();
			case (p)
				1: phase_seed = '1;
				3: phase_seed = '0;
				5: phase_seed = 64'hAAAA_5555_0F0F_F0F0;
				default: phase_seed = {$urandom, $urandom};
			endcase
			write_seed(phase_seed);
			steady <= (p == 2);
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (k == 100 || $urandom_range(199) == 0)
					drain();
				send_draw($urandom_range(11) == 0);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

/* filelist.f */
design/xss_pkg.sv
design/xss_front.sv
design/xss_splitmix.sv
design/xss_back.sv
design/xoshiro256_starstar_generator.sv
tb/sv/xss_draw_checker.sv
tb/sv/testbench.sv
